@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the search block datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge of clk, ignored while rst is high.
`define SABS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define SABS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SABS_ASSERT(lbl, prop, msg)
`define SABS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/core/sabs_pkg.sv @@
// Package: sizes, command codes, FSM states and control/status structs.
`timescale 1ns / 1ps

package sabs_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int POS_W  = 10;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_COMPARE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic do_clear;
    logic do_append;
    logic do_load;
    logic do_probe;
    logic do_step;
    logic do_hit;
    logic do_miss;
  } ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic in_range;
    logic eq;
  } stat_t;

endpackage

@@ rtl/core/sabs_ctrl.sv @@
// Controller FSM: decodes commands and sequences the binary search probes.
`timescale 1ns / 1ps

module sabs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     cmd,
  input  sabs_pkg::stat_t stat,
  output sabs_pkg::ctrl_t ctl,
  output logic           busy
);
  import sabs_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (cmd_t'(cmd))
            CMD_CLEAR:  ctl.do_clear = 1'b1;
            CMD_APPEND: ctl.do_append = 1'b1;
            CMD_SEARCH: begin
              ctl.do_load = 1'b1;
              state_next  = ST_CHECK;
            end
            default: ;  // unused code: transfer taken, nothing done
          endcase
        end
      end
      ST_CHECK: begin
        if (stat.in_range) begin
          ctl.do_probe = 1'b1;
          state_next   = ST_COMPARE;
        end else begin
          ctl.do_miss = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_COMPARE: begin
        if (stat.eq) begin
          ctl.do_hit = 1'b1;
          state_next = ST_IDLE;
        end else begin
          ctl.do_step = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

@@ rtl/core/sabs_dp.sv @@
// Datapath: element memory, count, search bounds, probe compare and result registers.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sabs_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  sabs_pkg::ctrl_t                   ctl,
  input  logic signed [sabs_pkg::DATA_W-1:0] value,
  output sabs_pkg::stat_t                   stat,
  output logic                              done,
  output logic                              found,
  output logic [sabs_pkg::POS_W-1:0]        position
);
  import sabs_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata;
  logic signed [DATA_W-1:0] key;
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         lo;      // lowest candidate index
  logic [CNT_W-1:0]         hi_ex;   // one past the highest candidate index
  logic [CNT_W-1:0]         mid;     // index of the probe in flight
  logic [CNT_W-1:0]         span;
  logic [CNT_W-1:0]         mid_next;

  // Probe index: lo + (hi - lo) / 2 with hi = hi_ex - 1
  assign span     = hi_ex - lo - CNT_W'(1);
  assign mid_next = lo + (span >> 1);

  assign stat.in_range = (lo < hi_ex);
  assign stat.eq       = (rdata == key);

  // Element memory: one write port for appends, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.do_append && (cnt < CNT_W'(DEPTH))) begin
      mem[cnt[ADDR_W-1:0]] <= value;
    end
    if (ctl.do_probe) begin
      rdata <= mem[mid_next[ADDR_W-1:0]];
    end
  end

  // Element count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.do_clear) begin
      cnt <= '0;
    end else if (ctl.do_append && (cnt < CNT_W'(DEPTH))) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  // Key capture and probe index
  always_ff @(posedge clk) begin
    if (ctl.do_load) begin
      key <= value;
    end
    if (ctl.do_probe) begin
      mid <= mid_next;
    end
  end

  // Search bounds: move right past a smaller probe, left onto a larger one
  always_ff @(posedge clk) begin
    if (rst) begin
      lo    <= '0;
      hi_ex <= '0;
    end else if (ctl.do_load) begin
      lo    <= '0;
      hi_ex <= cnt;
    end else if (ctl.do_step) begin
      if (rdata < key) begin
        lo <= mid + CNT_W'(1);
      end else begin
        hi_ex <= mid;
      end
    end
  end

  // Result registers: one-cycle strobe per search
  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      found    <= 1'b0;
      position <= '0;
    end else begin
      done <= ctl.do_hit | ctl.do_miss;
      if (ctl.do_hit) begin
        found    <= 1'b1;
        position <= mid[POS_W-1:0];
      end else if (ctl.do_miss) begin
        found    <= 1'b0;
        position <= '0;
      end
    end
  end

  `SABS_ASSERT(a_cnt_bound, (cnt <= CNT_W'(DEPTH)), "element count above capacity")
  `SABS_ASSERT(a_bounds_order, (lo <= hi_ex), "search bounds crossed past each other")
  `SABS_ASSERT(a_done_single, (done |=> !done), "result strobe held for two cycles")
  `SABS_ASSERT(a_miss_zero, ((done && !found) |-> (position == '0)), "miss with nonzero position")

endmodule

@@ rtl/core/sorted_array_binary_search.sv @@
// Top level: sorted array store with binary search lookup.
//
//  channel  | ports                       | transfer
//  ---------+-----------------------------+-----------------------------------
//  command  | start, busy, cmd, value     | rising edge with start=1, busy=0
//  result   | done, found, position       | every cycle with done=1
//
// Clear and append finish in the accepting cycle; busy stays low.
// A search runs probes, each a memory read in the check state and then a
// compare; a miss ends in a final check of the bounds, and the result
// strobe is high in the first cycle that busy is low again.
// rst is synchronous, active high, and empties the array.
// The receiver cannot stall: done is high for exactly one cycle per search.
`timescale 1ns / 1ps

module sorted_array_binary_search (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         cmd,
  input  logic signed [sabs_pkg::DATA_W-1:0] value,
  output logic                               done,
  output logic                               found,
  output logic [sabs_pkg::POS_W-1:0]         position
);
  import sabs_pkg::*;

  ctrl_t ctl;
  stat_t stat;

  sabs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  sabs_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .value    (value),
    .stat     (stat),
    .done     (done),
    .found    (found),
    .position (position)
  );

endmodule

@@ tb/tb_top.sv @@
// Testbench for the sorted array binary search block: directed tests, then random traffic.
`timescale 1ns / 1ps

module tb_top;
  import sabs_pkg::*;

  // Code that the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;
  localparam int RANDOM_ITEMS = 200;
  localparam int DRAIN_LIMIT = 200;
  localparam int SETTLE_CYCLES = 30;

  typedef struct {
    logic signed [DATA_W-1:0] key;
    logic                     found;
    logic [POS_W-1:0]         position;
  } lookup_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               cmd = CMD_CLEAR;
  logic signed [DATA_W-1:0] value = '0;
  logic                     done;
  logic                     found;
  logic [POS_W-1:0]         position;

  // Shadow copy of the array contents
  logic signed [DATA_W-1:0] stored_values [DEPTH];
  int                       stored_count = 0;
  lookup_t                  pending_lookups [$];
  lookup_t                  oldest_lookup;

  int mismatch_count = 0;
  int burst_left = 0;
  int n_search = 0;
  int n_hit = 0;
  int n_append = 0;
  int n_clear = 0;
  int n_unused = 0;
  int n_checked = 0;

  sorted_array_binary_search u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .value    (value),
    .done     (done),
    .found    (found),
    .position (position)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 50) begin
      $display("%0t ns mismatch: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // Updates the shadow array and queues the answer of a lookup
  task automatic predict_command(input logic [1:0] c, input logic signed [DATA_W-1:0] v);
    lookup_t ans;
    int lo;
    int hi;
    int mid;
    case (c)
      CMD_CLEAR: begin
        stored_count = 0;
        n_clear++;
      end
      CMD_APPEND: begin
        if (stored_count < DEPTH) begin
          stored_values[stored_count] = v;
          stored_count++;
        end
        n_append++;
      end
      CMD_SEARCH: begin
        ans.key = v;
        ans.found = 1'b0;
        ans.position = '0;
        lo = 0;
        hi = stored_count - 1;
        while (lo <= hi && !ans.found) begin
          mid = lo + (hi - lo) / 2;
          if (stored_values[mid] == v) begin
            ans.found = 1'b1;
            ans.position = mid[POS_W-1:0];
          end else if (stored_values[mid] < v) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
        pending_lookups.push_back(ans);
        n_search++;
        if (ans.found) n_hit++;
      end
      default: n_unused++;
    endcase
  endtask

  // Random bursts of back-to-back commands separated by idle gaps
  task automatic pace_sender();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
  endtask

  // One command transfer; returns at the edge that accepted it
  task automatic issue_command(input logic [1:0] c, input logic signed [DATA_W-1:0] v);
    start <= 1'b1;
    cmd <= c;
    value <= v;
    do @(posedge clk); while (busy);
    predict_command(c, v);
    pace_sender();
  endtask

  function automatic logic signed [DATA_W-1:0] pick_key();
    int r;
    int idx;
    r = $urandom_range(0, 9);
    idx = (stored_count > 0) ? $urandom_range(0, stored_count - 1) : 0;
    if (stored_count > 0 && r < 6) return stored_values[idx];
    if (stored_count > 0 && r < 9) return stored_values[idx] + ($urandom_range(0, 1) ? 1 : -1);
    return $urandom;
  endfunction

  // Appends n ascending values with a random step size
  task automatic append_sorted(input int n);
    longint cur;
    longint step_max;
    case ($urandom_range(0, 3))
      0: step_max = 2;
      1: step_max = 1000;
      2: step_max = 1 << 24;
      default: step_max = 1 << 30;
    endcase
    cur = longint'($signed($urandom));
    for (int i = 0; i < n; i++) begin
      issue_command(CMD_APPEND, cur[DATA_W-1:0]);
      cur = cur + longint'($urandom_range(0, int'(step_max)));
      if (cur > longint'(INT_MAX)) cur = longint'(INT_MAX);
    end
  endtask

  // Result checker: every strobe is matched against the oldest lookup
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch($sformatf("result with no lookup pending (found=%0b position=%0d)",
                                  found, position));
      end else begin
        oldest_lookup = pending_lookups.pop_front();
        if (found !== oldest_lookup.found) begin
          report_mismatch($sformatf("key %0d: found %0b, want %0b",
                                    oldest_lookup.key, found, oldest_lookup.found));
        end
        if (position !== oldest_lookup.position) begin
          report_mismatch($sformatf("key %0d: position %0d, want %0d",
                                    oldest_lookup.key, position, oldest_lookup.position));
        end
        n_checked++;
      end
    end
  end

  // Lookups on an empty array, with an unknown command mixed in
  task automatic test_empty_array();
    issue_command(CMD_SEARCH, 32'sd0);
    issue_command(CMD_UNUSED, INT_MAX);
    issue_command(CMD_SEARCH, INT_MIN);
    issue_command(CMD_SEARCH, INT_MAX);
  endtask

  // Extreme values of the signed range
  task automatic test_extremes();
    issue_command(CMD_CLEAR, -32'sd1);
    issue_command(CMD_APPEND, INT_MIN);
    issue_command(CMD_APPEND, -32'sd1);
    issue_command(CMD_APPEND, 32'sd0);
    issue_command(CMD_APPEND, 32'sd1);
    issue_command(CMD_APPEND, INT_MAX);
    issue_command(CMD_SEARCH, INT_MIN);
    issue_command(CMD_SEARCH, INT_MAX);
    issue_command(CMD_SEARCH, -32'sd1);
    issue_command(CMD_UNUSED, 32'sd0);
    issue_command(CMD_SEARCH, 32'sd1);
    issue_command(CMD_SEARCH, INT_MIN + 1);
  endtask

  // Repeated elements: the first probed match wins
  task automatic test_duplicates();
    issue_command(CMD_CLEAR, 32'sd0);
    repeat (3) issue_command(CMD_APPEND, 32'sd5);
    repeat (2) issue_command(CMD_APPEND, 32'sd7);
    issue_command(CMD_SEARCH, 32'sd5);
    issue_command(CMD_SEARCH, 32'sd7);
    issue_command(CMD_SEARCH, 32'sd6);
  endtask

  // Out-of-order contents follow the same probe sequence
  task automatic test_unsorted();
    issue_command(CMD_CLEAR, 32'sd0);
    issue_command(CMD_APPEND, 32'sd9);
    issue_command(CMD_APPEND, 32'sd3);
    issue_command(CMD_APPEND, 32'sd7);
    issue_command(CMD_APPEND, 32'sd1);
    issue_command(CMD_SEARCH, 32'sd3);
    issue_command(CMD_SEARCH, 32'sd1);
    issue_command(CMD_SEARCH, 32'sd9);
  endtask

  // Clear leaves old data unreachable
  task automatic test_clear_reuse();
    issue_command(CMD_CLEAR, 32'sd0);
    issue_command(CMD_SEARCH, 32'sd9);
    issue_command(CMD_APPEND, 32'sd42);
    issue_command(CMD_SEARCH, 32'sd42);
  endtask

  // Fill to capacity, then append past it
  task automatic test_full_array();
    issue_command(CMD_CLEAR, 32'sd0);
    for (int i = 0; i < DEPTH; i++) issue_command(CMD_APPEND, i * 3 - 1500);
    issue_command(CMD_SEARCH, -32'sd1500);
    issue_command(CMD_SEARCH, (DEPTH - 1) * 3 - 1500);
    issue_command(CMD_SEARCH, 32'sd0);
    issue_command(CMD_SEARCH, 32'sd1);
    issue_command(CMD_APPEND, INT_MAX);
    issue_command(CMD_SEARCH, INT_MAX);
    issue_command(CMD_SEARCH, (DEPTH - 2) * 3 - 1500);
  endtask

  // Mostly well-formed fill-then-lookup rounds, with noise in between
  task automatic test_random();
    int items;
    int r;
    int n;
    items = 0;
    while (items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        n = ($urandom_range(0, 39) == 0) ? $urandom_range(64, 256) : $urandom_range(1, 40);
        issue_command(CMD_CLEAR, $urandom);
        append_sorted(n);
        items += n + 1;
        repeat ($urandom_range(3, 12)) begin
          issue_command(CMD_SEARCH, pick_key());
          items++;
        end
      end else if (r < 8) begin
        n = $urandom_range(1, 8);
        repeat (n) issue_command(CMD_APPEND, $urandom);
        repeat (3) issue_command(CMD_SEARCH, pick_key());
        items += n + 3;
      end else begin
        issue_command(CMD_UNUSED, $urandom);
        if ($urandom_range(0, 1)) begin
          issue_command(CMD_CLEAR, $urandom);
          items++;
        end
        issue_command(CMD_SEARCH, pick_key());
        items++;
      end
    end
  endtask

  initial begin
    int waited;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_array();
    test_extremes();
    test_duplicates();
    test_unsorted();
    test_clear_reuse();
    test_full_array();
    test_random();

    // Drain outstanding lookups, then let the block settle
    start <= 1'b0;
    waited = 0;
    while (pending_lookups.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_lookups.size() > 0) begin
      report_mismatch($sformatf("%0d lookups never answered", pending_lookups.size()));
    end

    $display("tb_top: %0d lookups checked (%0d hits, %0d misses)",
             n_checked, n_hit, n_search - n_hit);
    $display("tb_top: %0d appends, %0d clears, %0d unknown commands, %0d mismatches",
             n_append, n_clear, n_unused, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/sabs_pkg.sv
rtl/core/sabs_ctrl.sv
rtl/core/sabs_dp.sv
rtl/core/sorted_array_binary_search.sv
tb/tb_top.sv
